// ----- hdl/ntir_pkg.sv -----
package ntir_pkg;

    // sizes fixed by the request fields
    localparam int NAME_BYTES         = 29;
    localparam int NAME_BITS          = 8 * NAME_BYTES;
    localparam int MAX_NAME_BYTES     = 29;
    localparam int DEF_TABLE_ENTRIES  = 32;

    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] name_word0;
        logic [63:0] name_word1;
        logic [63:0] name_word2;
        logic [39:0] name_word3;
        logic [4:0]  name_length;
        logic [6:0]  requester_id;
    } req_t;

    typedef struct packed {
        logic [6:0] found_id;
        logic       found;
        logic       status;
    } rsp_t;

    // one table row as held in the entry ram
    typedef struct packed {
        logic [6:0]           owner_id;
        logic [4:0]           name_length;
        logic [NAME_BITS-1:0] name_bits;
    } entry_t;

    typedef enum logic [1:0] {
        REPLY_OK   = 2'd0,
        REPLY_FULL = 2'd1,
        REPLY_HIT  = 2'd2,
        REPLY_MISS = 2'd3
    } reply_t;

    typedef struct packed {
        logic   capture;
        logic   append;
        logic   scan_start;
        logic   scan_next;
        logic   reply;
        reply_t reply_kind;
    } cmd_t;

    typedef struct packed {
        logic is_register;
        logic full;
        logic empty;
        logic last;
        logic hit;
    } stat_t;

    // clamp the length and clear every byte past it
    function automatic entry_t clean_name(input req_t r);
        logic [NAME_BITS-1:0] raw;
        logic [4:0]           len;
        entry_t               e;
        raw = {r.name_word3, r.name_word2, r.name_word1, r.name_word0};
        len = (r.name_length > 5'(MAX_NAME_BYTES)) ? 5'(MAX_NAME_BYTES) : r.name_length;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            e.name_bits[8*b +: 8] = (5'(b) < len) ? raw[8*b +: 8] : 8'h00;
        end
        e.owner_id    = r.requester_id;
        e.name_length = len;
        return e;
    endfunction

endpackage

// ----- hdl/ntir_ram.sv -----
module ntir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ntir_ctrl.sv -----
module ntir_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    input  ntir_pkg::stat_t stat,
    output ntir_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    // pend: read data of the previous cycle is valid; last: it was the final used row
    logic   pend_reg, pend_next;
    logic   last_reg, last_next;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        pend_next      = pend_reg;
        last_next      = last_reg;
        cmd            = '0;
        cmd.reply_kind = ntir_pkg::REPLY_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                pend_next = 1'b0;
                last_next = 1'b0;
                if (start)
                begin
                    done_next = 1'b1;
                    cmd.reply = 1'b1;
                    if (stat.is_register)
                    begin
                        if (stat.full)
                        begin
                            cmd.reply_kind = ntir_pkg::REPLY_FULL;
                        end
                        else
                        begin
                            cmd.append     = 1'b1;
                            cmd.reply_kind = ntir_pkg::REPLY_OK;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.reply_kind = ntir_pkg::REPLY_MISS;
                    end
                    else
                    begin
                        done_next      = 1'b0;
                        cmd.reply      = 1'b0;
                        cmd.capture    = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_next = 1'b1;
                pend_next     = 1'b1;
                last_next     = stat.last;
                if (pend_reg && stat.hit)
                begin
                    cmd.reply      = 1'b1;
                    cmd.reply_kind = ntir_pkg::REPLY_HIT;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (pend_reg && last_reg)
                begin
                    cmd.reply      = 1'b1;
                    cmd.reply_kind = ntir_pkg::REPLY_MISS;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            last_reg  <= last_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ----- hdl/ntir_datapath.sv -----
module ntir_datapath #(
    parameter int TABLE_ENTRIES = ntir_pkg::DEF_TABLE_ENTRIES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ntir_pkg::req_t  request,
    input  ntir_pkg::cmd_t  cmd,
    output ntir_pkg::stat_t stat,
    output ntir_pkg::rsp_t  result
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    ntir_pkg::entry_t               clean;
    ntir_pkg::entry_t               rd_entry;
    logic [ntir_pkg::NAME_BITS-1:0] q_name_reg;
    logic [4:0]                     q_len_reg;
    logic [CNT_W-1:0]               used_reg, used_next;
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    ntir_pkg::rsp_t                 rsp_reg, rsp_next;

    assign clean = ntir_pkg::clean_name(request);

    ntir_ram #(
        .WIDTH ($bits(ntir_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (clean),
        .raddr (rd_idx_reg),
        .rdata (rd_entry)
    );

    assign stat.is_register = (request.operation == ntir_pkg::OP_REGISTER);
    assign stat.full        = (used_reg == CNT_W'(TABLE_ENTRIES));
    assign stat.empty       = (used_reg == '0);
    assign stat.last        = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == used_reg);
    assign stat.hit         = (rd_entry.name_length == q_len_reg)
                              && (rd_entry.name_bits == q_name_reg);

    always_comb
    begin
        used_next   = used_reg;
        rd_idx_next = rd_idx_reg;
        rsp_next    = rsp_reg;
        if (cmd.append)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        if (cmd.scan_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.scan_next)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
        if (cmd.reply)
        begin
            rsp_next = '0;
            unique case (cmd.reply_kind)
                ntir_pkg::REPLY_OK:
                begin
                    rsp_next = '0;
                end
                ntir_pkg::REPLY_FULL:
                begin
                    rsp_next.status = ntir_pkg::STATUS_FULL;
                end
                ntir_pkg::REPLY_HIT:
                begin
                    rsp_next.found_id = rd_entry.owner_id;
                    rsp_next.found    = 1'b1;
                end
                ntir_pkg::REPLY_MISS:
                begin
                    rsp_next = '0;
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_name_reg <= clean.name_bits;
            q_len_reg  <= clean.name_length;
        end
        rsp_reg <= rsp_next;
    end

    assign result = rsp_reg;

endmodule

// ----- hdl/name_to_id_registry_core.sv -----
// name registry: a request is taken when start is high and busy is low. a register
// request writes the cleaned name into the next free row of the entry ram, or
// answers full when the table is full; its answer is registered. a lookup reads the
// used rows one per cycle from row 0 through the single ram read port, comparing
// each row in the cycle after its read, and answers from the registered result
// once a row matches or the last used row has been compared without a match; a
// lookup on an empty table answers a miss without scanning. done is high for
// exactly one cycle and cannot be held off, and result keeps the answer until the
// next one; a new request may be taken in that same cycle.
module name_to_id_registry_core #(
    parameter int TABLE_ENTRIES = ntir_pkg::DEF_TABLE_ENTRIES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ntir_pkg::req_t request,
    output logic           done,
    output ntir_pkg::rsp_t result
);

    ntir_pkg::cmd_t  cmd;
    ntir_pkg::stat_t stat;

    ntir_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    ntir_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule
